/* hw/rtl/sogc_pkg.sv */
package sogc_pkg;

    localparam int PIX_W    = 8;
    localparam int OFFSET_W = 9;
    localparam int GAIN_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [1:0] {
        VERDICT_NONE   = 2'd0,
        VERDICT_BRIGHT = 2'd1,
        VERDICT_DARK   = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        OUT_SETTLED     = 2'd0,
        OUT_CONTINUE    = 2'd1,
        OUT_BRIGHT_DONE = 2'd2,
        OUT_DARK_DONE   = 2'd3
    } t_outcome;

    typedef enum logic {
        CMP_ABOVE = 1'b0,
        CMP_BELOW = 1'b1
    } t_cmp_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHT_LIMIT = 3'd0,
        REG_DARK_LIMIT   = 3'd1,
        REG_OFFSET_UPPER = 3'd2,
        REG_OFFSET_LOWER = 3'd3,
        REG_GAIN_UPPER   = 3'd4,
        REG_GAIN_LOWER   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [PIX_W-1:0]    bright_limit;
        logic [PIX_W-1:0]    dark_limit;
        logic [OFFSET_W-1:0] offset_upper;
        logic [OFFSET_W-1:0] offset_lower;
        logic [GAIN_W-1:0]   gain_upper;
        logic [GAIN_W-1:0]   gain_lower;
    } t_cfg;

    typedef struct packed {
        logic [OFFSET_W-1:0] new_offset;
        logic [GAIN_W-1:0]   new_gain;
        t_outcome            outcome;
    } t_result;

    localparam logic [PIX_W-1:0]    BRIGHT_LIMIT_RST = 8'd240;
    localparam logic [PIX_W-1:0]    DARK_LIMIT_RST   = 8'd10;
    localparam logic [OFFSET_W-1:0] OFFSET_UPPER_RST = 9'd383;
    localparam logic [OFFSET_W-1:0] OFFSET_LOWER_RST = 9'd0;
    localparam logic [GAIN_W-1:0]   GAIN_UPPER_RST   = 4'd13;
    localparam logic [GAIN_W-1:0]   GAIN_LOWER_RST   = 4'd5;

    localparam t_cfg CFG_RST = '{
        bright_limit: BRIGHT_LIMIT_RST,
        dark_limit:   DARK_LIMIT_RST,
        offset_upper: OFFSET_UPPER_RST,
        offset_lower: OFFSET_LOWER_RST,
        gain_upper:   GAIN_UPPER_RST,
        gain_lower:   GAIN_LOWER_RST
    };

endpackage

/* hw/rtl/sogc_lane.sv */
module sogc_lane import sogc_pkg::*; (
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [PIX_W-1:0] i_limit,
    input  t_cmp_mode        i_mode,
    output logic             o_violation
);

    always_comb begin
        case (i_mode)
            CMP_ABOVE: o_violation = (i_pixel > i_limit);
            CMP_BELOW: o_violation = (i_pixel < i_limit);
            default:   o_violation = 1'b0;
        endcase
    end

endmodule

/* hw/rtl/sogc_merge.sv */
module sogc_merge import sogc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic     i_last,
    input  logic     i_top_bright,
    input  logic     i_mid_dark,
    input  logic     i_bot_bright,
    output t_verdict o_frame_verdict
);

    t_verdict r_verdict;
    t_verdict n_verdict;
    t_verdict col_verdict;

    // top beats middle beats bottom within one column
    always_comb begin
        if (i_top_bright) begin
            col_verdict = VERDICT_BRIGHT;
        end else if (i_mid_dark) begin
            col_verdict = VERDICT_DARK;
        end else if (i_bot_bright) begin
            col_verdict = VERDICT_BRIGHT;
        end else begin
            col_verdict = VERDICT_NONE;
        end
    end

    // an earlier column's violation sticks for the rest of the frame
    assign o_frame_verdict = (r_verdict != VERDICT_NONE) ? r_verdict : col_verdict;

    always_comb begin
        n_verdict = r_verdict;
        if (i_accept) begin
            n_verdict = i_last ? VERDICT_NONE : o_frame_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verdict <= VERDICT_NONE;
        end else begin
            r_verdict <= n_verdict;
        end
    end

endmodule

/* hw/rtl/sogc_step.sv */
module sogc_step import sogc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_verdict i_verdict,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    logic [OFFSET_W-1:0] r_offset;
    logic [GAIN_W-1:0]   r_gain;
    logic [OFFSET_W-1:0] n_offset;
    logic [GAIN_W-1:0]   n_gain;
    logic [OFFSET_W-1:0] step_offset;
    logic [GAIN_W-1:0]   step_gain;
    t_outcome            outcome;
    logic                terminal;

    always_comb begin
        step_offset = r_offset;
        step_gain   = r_gain;
        outcome     = OUT_SETTLED;
        terminal    = 1'b1;
        case (i_verdict)
            VERDICT_BRIGHT: begin
                if (r_offset < i_cfg.offset_upper) begin
                    step_offset = r_offset + OFFSET_W'(1);
                    outcome     = OUT_CONTINUE;
                    terminal    = 1'b0;
                end else if (r_gain > i_cfg.gain_lower) begin
                    step_gain   = r_gain - GAIN_W'(1);
                    step_offset = i_cfg.offset_upper;
                    outcome     = OUT_CONTINUE;
                    terminal    = 1'b0;
                end else begin
                    outcome = OUT_BRIGHT_DONE;
                end
            end
            VERDICT_DARK: begin
                if (r_offset > i_cfg.offset_lower) begin
                    step_offset = r_offset - OFFSET_W'(1);
                    outcome     = OUT_CONTINUE;
                    terminal    = 1'b0;
                end else if (r_gain < i_cfg.gain_upper) begin
                    step_gain   = r_gain + GAIN_W'(1);
                    step_offset = i_cfg.offset_upper;
                    outcome     = OUT_CONTINUE;
                    terminal    = 1'b0;
                end else begin
                    outcome = OUT_DARK_DONE;
                end
            end
            default: begin
                outcome = OUT_SETTLED;
            end
        endcase
    end

    // terminal outcomes report the settings just used, then restart the pass
    assign o_result = '{new_offset: step_offset, new_gain: step_gain, outcome: outcome};

    always_comb begin
        n_offset = r_offset;
        n_gain   = r_gain;
        if (i_step) begin
            n_offset = terminal ? i_cfg.offset_upper : step_offset;
            n_gain   = terminal ? i_cfg.gain_upper   : step_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_UPPER_RST;
            r_gain   <= GAIN_UPPER_RST;
        end else begin
            r_offset <= n_offset;
            r_gain   <= n_gain;
        end
    end

endmodule

/* hw/rtl/sensor_offset_gain_calibrator_top.sv */
// Channel   Dir  Signals                                 Content
// s_*       in   s_tvalid s_tready s_tdata s_tlast       one scan column
// m_*       out  m_tvalid m_tready m_tdata m_tuser       new settings and outcome
// cfg       in   i_cfg_valid o_cfg_ready addr data       register write
//
// One column accepted every cycle while s_tready is high; the lane compares
// and the offset/gain step sit between the input and the verdict/settings
// registers, and the result of a last column goes to the output or skid register.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// Output register plus one skid entry: columns keep flowing while a result
// waits; s_tready drops only when both entries hold results.
module sensor_offset_gain_calibrator_top import sogc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // top_pixel, middle_pixel, bottom_pixel
    input  logic                  s_tlast,   // last_column
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // new_offset, new_gain, 3'b0 pad
    output logic [1:0]            m_tuser,   // outcome
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     in_accept;
    logic     top_bright;
    logic     mid_dark;
    logic     bot_bright;
    t_verdict frame_verdict;
    t_result  result;

    logic     r_out_valid;
    logic     r_skid_valid;
    t_result  r_out_data;
    t_result  r_skid_data;
    logic     n_out_valid;
    logic     n_skid_valid;
    t_result  n_out_data;
    t_result  n_skid_data;
    logic     take;
    logic     push;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_BRIGHT_LIMIT: r_cfg.bright_limit <= i_cfg_data[PIX_W-1:0];
                REG_DARK_LIMIT:   r_cfg.dark_limit   <= i_cfg_data[PIX_W-1:0];
                REG_OFFSET_UPPER: r_cfg.offset_upper <= i_cfg_data[OFFSET_W-1:0];
                REG_OFFSET_LOWER: r_cfg.offset_lower <= i_cfg_data[OFFSET_W-1:0];
                REG_GAIN_UPPER:   r_cfg.gain_upper   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_LOWER:   r_cfg.gain_lower   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready  = !r_skid_valid;
    assign in_accept = s_tvalid && s_tready;

    sogc_lane u_lane_top (
        .i_pixel     (s_tdata[7:0]),
        .i_limit     (r_cfg.bright_limit),
        .i_mode      (CMP_ABOVE),
        .o_violation (top_bright)
    );

    sogc_lane u_lane_mid (
        .i_pixel     (s_tdata[15:8]),
        .i_limit     (r_cfg.dark_limit),
        .i_mode      (CMP_BELOW),
        .o_violation (mid_dark)
    );

    sogc_lane u_lane_bot (
        .i_pixel     (s_tdata[23:16]),
        .i_limit     (r_cfg.bright_limit),
        .i_mode      (CMP_ABOVE),
        .o_violation (bot_bright)
    );

    sogc_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_last          (s_tlast),
        .i_top_bright    (top_bright),
        .i_mid_dark      (mid_dark),
        .i_bot_bright    (bot_bright),
        .o_frame_verdict (frame_verdict)
    );

    assign push = in_accept && s_tlast;

    sogc_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (push),
        .i_verdict (frame_verdict),
        .i_cfg     (r_cfg),
        .o_result  (result)
    );

    assign take = r_out_valid && m_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (take) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (push) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_out_data.new_gain, r_out_data.new_offset};
    assign m_tuser  = r_out_data.outcome;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_no_result_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !s_tlast && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared without a last column");

    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && s_tlast) |=> m_tvalid)
        else $error("last column produced no result");
`endif

endmodule
